>>> design/swrm_pkg.sv
// ----------------------------------------------------------------------------
// swrm_pkg
// shared types and constants of the sliding window rate meter
// ----------------------------------------------------------------------------
package swrm_pkg;

  localparam int T_W      = 63;   // timestamp width
  localparam int SPAN_W   = 40;   // window span width, also divisor width
  localparam int STAT_W   = 40;   // Q32.8 statistics width
  localparam int SQ_IN_W  = 2 * STAT_W;
  localparam int MEAN_FRAC = 8;
  localparam int VAR_FRAC  = 16;

  localparam logic [STAT_W-1:0] STAT_MAX   = {STAT_W{1'b1}};
  localparam logic [SPAN_W-1:0] SPAN_RESET = 40'd1000000000;

  // register index, taken from paddr[3]
  localparam logic REG_SPAN  = 1'b0;
  localparam logic REG_START = 1'b1;

  typedef enum logic [0:0] {
    OP_HIT   = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef struct packed {
    op_t            op;
    logic [T_W-1:0] time_ns;
  } item_t;

  typedef struct packed {
    logic              available;
    logic [STAT_W-1:0] mean;
    logic [STAT_W-1:0] std;
  } result_t;

endpackage

>>> design/sliding_window_rate_meter_unit.sv
// ----------------------------------------------------------------------------
// sliding_window_rate_meter_unit
// bucketed sliding-window hit counter with mean and deviation queries
// ----------------------------------------------------------------------------
// Each request transaction carries a timestamp and is either a hit or a
// query. A two-entry queue in the front end takes requests while the back end
// works; the back end handles one request at a time. Every request in the
// window first runs a restoring divide (time - oldest start) / span, one bit
// per cycle over DIVN_W bits (95 at default sizes), then clears one bucket
// per cycle for each window slid past, up to HISTORY_DEPTH. A hit then
// updates its bucket and gives no response. A query sums the buckets, one
// per cycle, runs a second divide for the mean and, with more than one
// bucket, computes the squared deviations on a single 19x19 multiplier, a
// third divide for the variance and a bit-serial square root. A request
// earlier than the oldest window skips the divide: a hit is dropped and a
// query is answered with no statistics available. The response sits in an
// output register, so the next request is taken while a response waits.
// Writing the start time register restarts the meter at once.
// ----------------------------------------------------------------------------
module sliding_window_rate_meter_unit #(
  parameter int HISTORY_DEPTH = 16,
  parameter int COUNT_WIDTH   = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  // request channel
  input  logic                          req_valid,
  output logic                          req_ready,
  input  logic                          req_type,
  input  logic [swrm_pkg::T_W-1:0]      time_ns,
  // response channel
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output logic                          available,
  output logic [swrm_pkg::STAT_W-1:0]   mean_per_window,
  output logic [swrm_pkg::STAT_W-1:0]   std_per_window,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [3:0]                    paddr,
  input  logic [63:0]                   pwdata,
  output logic [63:0]                   prdata,
  output logic                          pready
);

  logic [swrm_pkg::SPAN_W-1:0] window_span_ns;
  logic [swrm_pkg::T_W-1:0]    start_ns;
  logic                        cfg_wr;
  logic                        restart;

  logic                        q_valid;
  swrm_pkg::item_t             q_item;
  logic                        q_pop;
  logic                        res_valid;
  swrm_pkg::result_t           res;
  logic                        res_ready;
  swrm_pkg::result_t           rsp;

  // register file: span at 0x0, start time at 0x8
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign restart = cfg_wr && (paddr[3] == swrm_pkg::REG_START);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_span_ns <= swrm_pkg::SPAN_RESET;
      start_ns       <= '0;
    end else if (cfg_wr) begin
      if (paddr[3] == swrm_pkg::REG_SPAN) begin
        window_span_ns <= pwdata[swrm_pkg::SPAN_W-1:0];
      end else begin
        start_ns <= pwdata[swrm_pkg::T_W-1:0];
      end
    end
  end

  always_comb begin
    case (paddr[3])
      swrm_pkg::REG_SPAN: prdata = 64'(window_span_ns);
      default:            prdata = 64'(start_ns);
    endcase
  end

  swrm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_type  (req_type),
    .time_ns   (time_ns),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  swrm_engine #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .COUNT_WIDTH   (COUNT_WIDTH)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .span       (window_span_ns),
    .restart    (restart),
    .load_start (pwdata[swrm_pkg::T_W-1:0]),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .res_valid  (res_valid),
    .res        (res),
    .res_ready  (res_ready)
  );

  // response register, reloads as soon as the held transaction is taken
  assign res_ready = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      rsp <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_ready) begin
      rsp_valid <= res_valid;
    end
  end

  assign available       = rsp.available;
  assign mean_per_window = rsp.mean;
  assign std_per_window  = rsp.std;

endmodule

>>> design/swrm_front.sv
// ----------------------------------------------------------------------------
// swrm_front
// accepts request transactions, classifies them and queues them for the engine
// ----------------------------------------------------------------------------
module swrm_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_ready,
  input  logic                   req_type,
  input  logic [swrm_pkg::T_W-1:0] time_ns,
  output logic                   q_valid,
  output swrm_pkg::item_t        q_item,
  input  logic                   q_pop
);

  swrm_pkg::item_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  swrm_pkg::item_t item_in;

  always_comb begin
    item_in.op      = req_type ? swrm_pkg::OP_QUERY : swrm_pkg::OP_HIT;
    item_in.time_ns = time_ns;
  end

  assign req_ready = (count != 2'd2);
  assign push      = req_valid && req_ready;
  assign q_valid   = (count != 2'd0);
  assign q_item    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule

>>> design/swrm_div.sv
// ----------------------------------------------------------------------------
// swrm_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module swrm_div #(
  parameter int NUM_W = 94,
  parameter int DEN_W = 40
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot,
  output logic [DEN_W-1:0] rem
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_sh;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W:0]   trial;
  logic             ge;

  assign trial = {rem_r, num_sh[NUM_W-1]};
  assign ge    = (trial >= {1'b0, den_r});
  assign quot  = num_sh;
  assign rem   = rem_r;

  always_ff @(posedge clk) begin
    if (start) begin
      num_sh <= num;
      rem_r  <= '0;
      den_r  <= den;
    end else if (busy) begin
      num_sh <= {num_sh[NUM_W-2:0], ge};
      rem_r  <= ge ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> design/swrm_sqrt.sv
// ----------------------------------------------------------------------------
// swrm_sqrt
// integer square root, one result bit per cycle
// ----------------------------------------------------------------------------
module swrm_sqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [swrm_pkg::SQ_IN_W-1:0] x,
  output logic                         done,
  output logic [swrm_pkg::STAT_W-1:0]  root
);

  localparam int R_W   = swrm_pkg::STAT_W;
  localparam int CNT_W = $clog2(R_W + 1);

  logic [2*R_W-1:0] xs;
  logic [R_W:0]     rem_r;
  logic [R_W-1:0]   root_r;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [R_W+2:0]   shifted;
  logic [R_W+2:0]   trial;
  logic             ge;

  assign shifted = {rem_r, xs[2*R_W-1:2*R_W-2]};
  assign trial   = {1'b0, root_r, 2'b01};
  assign ge      = (shifted >= trial);
  assign root    = root_r;

  always_ff @(posedge clk) begin
    if (start) begin
      xs     <= x;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy) begin
      xs     <= {xs[2*R_W-3:0], 2'b00};
      rem_r  <= ge ? (R_W+1)'(shifted - trial) : shifted[R_W:0];
      root_r <= {root_r[R_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(R_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> design/swrm_engine.sv
// ----------------------------------------------------------------------------
// swrm_engine
// back end: window slide, bucket update and query statistics sequencer
// ----------------------------------------------------------------------------
module swrm_engine #(
  parameter int HISTORY_DEPTH = 16,
  parameter int COUNT_WIDTH   = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [swrm_pkg::SPAN_W-1:0]   span,
  input  logic                          restart,
  input  logic [swrm_pkg::T_W-1:0]      load_start,
  input  logic                          q_valid,
  input  swrm_pkg::item_t               q_item,
  output logic                          q_pop,
  output logic                          res_valid,
  output swrm_pkg::result_t             res,
  input  logic                          res_ready
);

  localparam int HD     = HISTORY_DEPTH;
  localparam int CW     = COUNT_WIDTH;
  localparam int T_W    = swrm_pkg::T_W;
  localparam int SPAN_W = swrm_pkg::SPAN_W;
  localparam int STAT_W = swrm_pkg::STAT_W;
  localparam int IDX_W  = (HD > 1) ? $clog2(HD) : 1;
  localparam int N_W    = $clog2(HD + 1);
  localparam int SUM_W  = CW + N_W;
  localparam int DV_W   = CW + N_W;
  localparam int HALF   = (DV_W + 1) / 2;
  localparam int ACC_W  = 2 * DV_W + N_W;
  localparam int DD_W   = 2 * N_W + IDX_W;
  localparam int NUM_A  = (ACC_W + swrm_pkg::VAR_FRAC > T_W) ?
                          ACC_W + swrm_pkg::VAR_FRAC : T_W;
  localparam int DIVN_W = (SUM_W + swrm_pkg::MEAN_FRAC > NUM_A) ?
                          SUM_W + swrm_pkg::MEAN_FRAC : NUM_A;
  localparam int XW     = (DIVN_W > swrm_pkg::SQ_IN_W) ? DIVN_W : swrm_pkg::SQ_IN_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HD - 1);

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_SDIV = 13'b0000000000010,
    S_CLR  = 13'b0000000000100,
    S_HIT  = 13'b0000000001000,
    S_SUM  = 13'b0000000010000,
    S_MDIV = 13'b0000000100000,
    S_VNC  = 13'b0000001000000,
    S_VDV  = 13'b0000010000000,
    S_VMUL = 13'b0000100000000,
    S_VACC = 13'b0001000000000,
    S_VDIV = 13'b0010000000000,
    S_SQRT = 13'b0100000000000,
    S_EMIT = 13'b1000000000000
  } state_t;

  typedef enum logic [1:0] {
    M_LL = 2'd0,
    M_LH = 2'd1,
    M_HH = 2'd2
  } mstep_t;

  state_t state;

  logic [CW-1:0]      buckets [HD];
  logic [IDX_W-1:0]   head;
  logic [T_W-1:0]     oldest;
  logic [T_W-1:0]     span_mul;
  swrm_pkg::op_t      op;
  logic [T_W-1:0]     t_r;
  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   i;
  logic [N_W-1:0]     clr_cnt;
  logic [SUM_W-1:0]   sum;
  logic [2*N_W-1:0]   nn;
  logic [DD_W-1:0]    dd;
  logic [DV_W-1:0]    nc;
  logic [DV_W-1:0]    dv;
  logic [2*HALF-1:0]  prod;
  mstep_t             mstep;
  logic [ACC_W-1:0]   acc;
  logic               avail;
  logic [STAT_W-1:0]  mean;
  logic [STAT_W-1:0]  std;

  // divider and root unit control
  logic               div_go;
  logic [DIVN_W-1:0]  div_num;
  logic [SPAN_W-1:0]  div_den;
  logic               div_done;
  logic [DIVN_W-1:0]  div_quot;
  logic [SPAN_W-1:0]  div_rem;
  logic               sq_go;
  logic [swrm_pkg::SQ_IN_W-1:0] sq_x;
  logic               sq_done;
  logic [STAT_W-1:0]  sq_root;

  // combinational helpers
  logic [SPAN_W-1:0]  span_eff;
  logic [IDX_W:0]     slot_sum;
  logic [IDX_W-1:0]   rd_slot;
  logic [CW-1:0]      bucket_rd;
  logic [N_W-1:0]     n_cur;
  logic [SUM_W-1:0]   sum_new;
  logic [T_W-1:0]     qv;
  logic [T_W-1:0]     kv;
  logic [2*HALF-1:0]  dv_ext;
  logic [HALF-1:0]    mul_a;
  logic [HALF-1:0]    mul_b;
  logic [ACC_W-1:0]   acc_term;
  logic [ACC_W-1:0]   acc_new;
  logic [XW-1:0]      x_ext;

  assign span_eff  = (span == '0) ? SPAN_W'(1) : span;
  assign slot_sum  = {1'b0, head} + {1'b0, i};
  assign rd_slot   = (slot_sum >= (IDX_W+1)'(HD)) ? IDX_W'(slot_sum - (IDX_W+1)'(HD))
                                                  : slot_sum[IDX_W-1:0];
  assign bucket_rd = buckets[rd_slot];
  assign n_cur     = N_W'(idx) + N_W'(1);
  assign sum_new   = sum + SUM_W'(bucket_rd);
  assign qv        = div_quot[T_W-1:0];
  assign kv        = qv - T_W'(HD - 1);
  assign dv_ext    = (2*HALF)'(dv);
  assign x_ext     = XW'(div_quot);

  always_comb begin
    case (mstep)
      M_LL: begin
        mul_a    = dv_ext[HALF-1:0];
        mul_b    = dv_ext[HALF-1:0];
      end
      M_LH: begin
        mul_a    = dv_ext[HALF-1:0];
        mul_b    = dv_ext[2*HALF-1:HALF];
      end
      default: begin
        mul_a    = dv_ext[2*HALF-1:HALF];
        mul_b    = dv_ext[2*HALF-1:HALF];
      end
    endcase
    case (mstep)
      M_LL:    acc_term = ACC_W'(prod);
      M_LH:    acc_term = ACC_W'(prod) << (HALF + 1);
      default: acc_term = ACC_W'(prod) << (2 * HALF);
    endcase
  end

  assign acc_new = acc + acc_term;

  assign q_pop     = (state == S_IDLE) && q_valid;
  assign res_valid = (state == S_EMIT);
  assign res.available = avail;
  assign res.mean      = mean;
  assign res.std       = std;

  // (HD-1) windows expressed in ns, refreshed every cycle
  always_ff @(posedge clk) begin
    span_mul <= T_W'(span_eff) * T_W'(LAST_IDX);
  end

  // datapath registers
  always_ff @(posedge clk) begin
    div_go <= 1'b0;
    sq_go  <= 1'b0;
    case (state)
      S_IDLE: begin
        op  <= q_item.op;
        t_r <= q_item.time_ns;
        if (q_valid) begin
          avail <= 1'b0;
          mean  <= '0;
          std   <= '0;
          div_go  <= (q_item.time_ns >= oldest);
          div_num <= DIVN_W'(q_item.time_ns - oldest);
          div_den <= span_eff;
        end
      end
      S_SDIV: begin
        sum <= '0;
        if (div_done) begin
          if (qv >= T_W'(HD)) begin
            clr_cnt <= (kv < T_W'(HD)) ? N_W'(kv) : N_W'(HD);
            idx     <= LAST_IDX;
            i       <= LAST_IDX;
          end else begin
            idx <= qv[IDX_W-1:0];
            i   <= (op == swrm_pkg::OP_HIT) ? qv[IDX_W-1:0] : '0;
          end
        end
      end
      S_CLR: begin
        clr_cnt <= clr_cnt - 1'b1;
        if (op == swrm_pkg::OP_QUERY) begin
          i <= '0;
        end
      end
      S_SUM: begin
        sum <= sum_new;
        nn  <= n_cur * n_cur;
        if (i == idx) begin
          div_go  <= 1'b1;
          div_num <= DIVN_W'(sum_new) << swrm_pkg::MEAN_FRAC;
          div_den <= SPAN_W'(n_cur);
        end else begin
          i <= i + 1'b1;
        end
      end
      S_MDIV: begin
        dd  <= DD_W'(nn) * DD_W'(idx);
        acc <= '0;
        i   <= '0;
        if (div_done) begin
          avail <= 1'b1;
          mean  <= (x_ext > XW'(swrm_pkg::STAT_MAX)) ? swrm_pkg::STAT_MAX
                                                     : div_quot[STAT_W-1:0];
        end
      end
      S_VNC: begin
        nc <= DV_W'(n_cur) * DV_W'(bucket_rd);
      end
      S_VDV: begin
        dv    <= (nc >= DV_W'(sum)) ? nc - DV_W'(sum) : DV_W'(sum) - nc;
        mstep <= M_LL;
      end
      S_VMUL: begin
        prod <= mul_a * mul_b;
      end
      S_VACC: begin
        acc <= acc_new;
        if (mstep == M_HH) begin
          if (i == idx) begin
            div_go  <= 1'b1;
            div_num <= DIVN_W'(acc_new) << swrm_pkg::VAR_FRAC;
            div_den <= SPAN_W'(dd);
          end else begin
            i <= i + 1'b1;
          end
        end else begin
          mstep <= (mstep == M_LL) ? M_LH : M_HH;
        end
      end
      S_VDIV: begin
        if (div_done) begin
          sq_x  <= div_quot[swrm_pkg::SQ_IN_W-1:0];
          sq_go <= ~|x_ext[XW-1:swrm_pkg::SQ_IN_W];
          if (|x_ext[XW-1:swrm_pkg::SQ_IN_W]) begin
            std <= swrm_pkg::STAT_MAX;
          end
        end
      end
      S_SQRT: begin
        if (sq_done) begin
          std <= sq_root;
        end
      end
      default: begin
      end
    endcase
  end

  // control state, ring and window start
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      head   <= '0;
      oldest <= '0;
      for (int b = 0; b < HD; b++) begin
        buckets[b] <= '0;
      end
    end else if (restart) begin
      head   <= '0;
      oldest <= load_start;
      for (int b = 0; b < HD; b++) begin
        buckets[b] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            if (q_item.time_ns >= oldest) begin
              state <= S_SDIV;
            end else if (q_item.op == swrm_pkg::OP_QUERY) begin
              state <= S_EMIT;
            end
          end
        end
        S_SDIV: begin
          if (div_done) begin
            if (qv >= T_W'(HD)) begin
              oldest <= t_r - T_W'(div_rem) - span_mul;
              state  <= S_CLR;
            end else begin
              state <= (op == swrm_pkg::OP_HIT) ? S_HIT : S_SUM;
            end
          end
        end
        S_CLR: begin
          buckets[head] <= '0;
          head <= (head == LAST_IDX) ? '0 : head + 1'b1;
          if (clr_cnt == N_W'(1)) begin
            state <= (op == swrm_pkg::OP_HIT) ? S_HIT : S_SUM;
          end
        end
        S_HIT: begin
          if (bucket_rd != {CW{1'b1}}) begin
            buckets[rd_slot] <= bucket_rd + 1'b1;
          end
          state <= S_IDLE;
        end
        S_SUM: begin
          if (i == idx) begin
            state <= S_MDIV;
          end
        end
        S_MDIV: begin
          if (div_done) begin
            state <= (idx == '0) ? S_EMIT : S_VNC;
          end
        end
        S_VNC:  state <= S_VDV;
        S_VDV:  state <= S_VMUL;
        S_VMUL: state <= S_VACC;
        S_VACC: begin
          if (mstep == M_HH) begin
            state <= (i == idx) ? S_VDIV : S_VNC;
          end else begin
            state <= S_VMUL;
          end
        end
        S_VDIV: begin
          if (div_done) begin
            state <= (|x_ext[XW-1:swrm_pkg::SQ_IN_W]) ? S_EMIT : S_SQRT;
          end
        end
        S_SQRT: begin
          if (sq_done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  swrm_div #(
    .NUM_W (DIVN_W),
    .DEN_W (SPAN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_go),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot),
    .rem   (div_rem)
  );

  swrm_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_go),
    .x     (sq_x),
    .done  (sq_done),
    .root  (sq_root)
  );

endmodule

>>> bench/swrm_rate_checker.sv
// ----------------------------------------------------------------------------
// swrm_rate_checker
// watches the request, response and configuration ports of the rate meter,
// predicts each query response from its own bucket model and compares
// ----------------------------------------------------------------------------
module swrm_rate_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  input  logic                        req_ready,
  input  logic                        req_type,
  input  logic [swrm_pkg::T_W-1:0]    time_ns,
  input  logic                        rsp_valid,
  input  logic                        rsp_ready,
  input  logic                        available,
  input  logic [swrm_pkg::STAT_W-1:0] mean_per_window,
  input  logic [swrm_pkg::STAT_W-1:0] std_per_window,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [3:0]                  paddr,
  input  logic [63:0]                 pwdata,
  output int                          errors,
  output int                          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;
  localparam int EXP_DEPTH = 64;
  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  logic [31:0]                 hits [DEPTH];
  logic [swrm_pkg::T_W-1:0]    oldest_start;
  logic [3:0]                  head;
  logic [swrm_pkg::SPAN_W-1:0] span_reg;
  logic [swrm_pkg::T_W-1:0]    start_reg;
  swrm_pkg::result_t           exp_mem [EXP_DEPTH];
  int unsigned                 exp_wr = 0;
  int unsigned                 exp_rd = 0;

  assign pending = int'(exp_wr - exp_rd);

  function automatic void restart_meter();
    for (int i = 0; i < DEPTH; i++) hits[i] = '0;
    head = '0;
    oldest_start = start_reg;
  endfunction

  // returns 1 when the transaction produces a response
  function automatic bit predict_rate(input swrm_pkg::op_t op,
                                      input logic [swrm_pkg::T_W-1:0] t,
                                      output swrm_pkg::result_t r);
    logic [63:0]  sp, q, k, n, sum, mean;
    logic [127:0] acc, x, d, nc, dv, c;
    logic [39:0]  root;
    logic [3:0]   s;
    r = '0;
    sp = (span_reg == 0) ? 64'd1 : 64'(span_reg);
    if (t < oldest_start) return op == swrm_pkg::OP_QUERY;
    q = 64'(t - oldest_start) / sp;
    // slide forward, clearing at most a full ring
    if (q >= DEPTH) begin
      k = q - (DEPTH - 1);
      for (int i = 0; i < DEPTH && i < k; i++) begin
        hits[head] = '0;
        head = head + 1'b1;
      end
      oldest_start = oldest_start + swrm_pkg::T_W'(k * sp);
      q = q - k;
    end
    if (op == swrm_pkg::OP_HIT) begin
      s = head + q[3:0];
      if (hits[s] != COUNT_MAX) hits[s] = hits[s] + 1;
      return 0;
    end
    n = q + 1;
    sum = '0;
    for (int i = 0; i <= q; i++) sum = sum + hits[4'(head + i)];
    if ((sum / n) > (64'(swrm_pkg::STAT_MAX) >> swrm_pkg::MEAN_FRAC))
      mean = 64'(swrm_pkg::STAT_MAX);
    else begin
      mean = ((sum / n) << swrm_pkg::MEAN_FRAC)
           + (((sum % n) << swrm_pkg::MEAN_FRAC) / n);
      if (mean > 64'(swrm_pkg::STAT_MAX)) mean = 64'(swrm_pkg::STAT_MAX);
    end
    r.available = 1'b1;
    r.mean = mean[swrm_pkg::STAT_W-1:0];
    // sample deviation with divisor idx, zero for a single bucket
    if (q != 0) begin
      acc = '0;
      for (int i = 0; i <= q; i++) begin
        nc = 128'(n) * 128'(hits[4'(head + i)]);
        dv = (nc >= 128'(sum)) ? nc - 128'(sum) : 128'(sum) - nc;
        acc = acc + dv * dv;
      end
      d = 128'(n * n * q);
      x = ((acc / d) << swrm_pkg::VAR_FRAC) + (((acc % d) << swrm_pkg::VAR_FRAC) / d);
      if (x >= (128'd1 << 80)) r.std = swrm_pkg::STAT_MAX;
      else begin
        root = '0;
        for (int b = 39; b >= 0; b--) begin
          c = 128'(root | (40'd1 << b));
          if (c * c <= x) root = root | (40'd1 << b);
        end
        r.std = root;
      end
    end
    return 1;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    swrm_pkg::result_t r;
    swrm_pkg::result_t want;
    if (rst) begin
      span_reg = swrm_pkg::SPAN_RESET;
      start_reg = '0;
      restart_meter();
      exp_rd = exp_wr;
      errors = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[3] == swrm_pkg::REG_SPAN) span_reg = pwdata[swrm_pkg::SPAN_W-1:0];
        else begin
          start_reg = pwdata[swrm_pkg::T_W-1:0];
          restart_meter();
        end
      end
      // response first: it can never belong to a request taken this edge
      if (rsp_valid && rsp_ready) begin
        if (exp_wr == exp_rd) report_mismatch("unexpected response", 0, 0);
        else begin
          want = exp_mem[exp_rd % EXP_DEPTH];
          exp_rd++;
          if (available != want.available)
            report_mismatch("available", available, want.available);
          if (mean_per_window != want.mean)
            report_mismatch("mean_per_window", mean_per_window, want.mean);
          if (std_per_window != want.std)
            report_mismatch("std_per_window", std_per_window, want.std);
        end
      end
      if (req_valid && req_ready)
        if (predict_rate(swrm_pkg::op_t'(req_type), time_ns, r)) begin
          exp_mem[exp_wr % EXP_DEPTH] = r;
          exp_wr++;
        end
    end
  end

endmodule

>>> bench/tb_sliding_window_rate_meter_unit.sv
// ----------------------------------------------------------------------------
// tb_sliding_window_rate_meter_unit
// drives timestamped hit and query transactions into the rate meter across
// several window spans and start times, with random gaps on both channels;
// a side checker predicts every response and counts mismatches
// ----------------------------------------------------------------------------
module tb_sliding_window_rate_meter_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [swrm_pkg::T_W-1:0] T_MAX = {swrm_pkg::T_W{1'b1}};
  localparam int SETTLE = 500;       // longest query plus margin, in cycles
  localparam int STALL_LIMIT = 20000;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        req_valid = 1'b0;
  logic                        req_ready;
  logic                        req_type = 1'b0;
  logic [swrm_pkg::T_W-1:0]    time_ns = '0;
  logic                        rsp_valid;
  logic                        rsp_ready = 1'b0;
  logic                        available;
  logic [swrm_pkg::STAT_W-1:0] mean_per_window;
  logic [swrm_pkg::STAT_W-1:0] std_per_window;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [3:0]                  paddr = '0;
  logic [63:0]                 pwdata = '0;
  logic [63:0]                 prdata;
  logic                        pready;

  int errors;
  int pending;
  int idle_cycles = 0;
  bit calm = 1'b0;                        // phases with no idling on either side
  logic [swrm_pkg::T_W-1:0] now_ns = '0;  // running timestamp of the well-formed stream

  always #10 clk = ~clk;

  sliding_window_rate_meter_unit DUT (
    .clk, .rst, .req_valid, .req_ready, .req_type, .time_ns,
    .rsp_valid, .rsp_ready, .available, .mean_per_window, .std_per_window,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  swrm_rate_checker u_checker (
    .clk, .rst, .req_valid, .req_ready, .req_type, .time_ns,
    .rsp_valid, .rsp_ready, .available, .mean_per_window, .std_per_window,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata, .errors, .pending
  );

  // idle length: mostly none or short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  // response side stalls at random
  always @(negedge clk) begin
    if (rst) rsp_ready <= 1'b0;
    else if (calm) rsp_ready <= 1'b1;
    else rsp_ready <= ($urandom_range(0, 99) < 60) || ($urandom_range(0, 99) < 3);
  end

  // watchdog: cycles with no transaction on any port
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready) || psel)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("sliding_window_rate_meter_unit test failed");
      $finish;
    end
  end

  // one request transaction, held until accepted
  task automatic send_req(input swrm_pkg::op_t op, input logic [swrm_pkg::T_W-1:0] t);
    repeat (gap_len()) @(negedge clk);
    req_valid = 1'b1;
    req_type = op;
    time_ns = t;
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
    req_valid = 1'b0;
    req_type = 1'($urandom_range(0, 1));
    time_ns = swrm_pkg::T_W'({$urandom, $urandom});
  endtask

  // two-phase register write, only with the meter idle
  task automatic write_reg(input logic idx, input logic [63:0] value);
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {idx, 3'b000};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // drain all responses, then let a trailing hit finish
  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_meter(input logic [swrm_pkg::SPAN_W-1:0] span,
                           input logic [swrm_pkg::T_W-1:0] start);
    drain();
    write_reg(swrm_pkg::REG_SPAN, 64'(span));
    write_reg(swrm_pkg::REG_START, 64'(start));
    now_ns = start;
  endtask

  // mostly well-formed streams advancing through the windows, plus noise
  task automatic random_phase(input logic [swrm_pkg::SPAN_W-1:0] span,
                              input logic [swrm_pkg::T_W-1:0] start,
                              input int count);
    logic [63:0] sp, step, t;
    int r;
    sp = (span == 0) ? 64'd1 : 64'(span);
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 80) step = ($urandom_range(0, 3) == 0) ? sp * $urandom_range(0, 2)
                                                       : ({$urandom, $urandom} % sp) / 4;
      else if (r < 90) step = sp * $urandom_range(15, 40);
      else step = 0;
      t = 64'(now_ns) + step;
      now_ns = (t > 64'(T_MAX)) ? T_MAX : t[swrm_pkg::T_W-1:0];
      if (r >= 97) begin
        // noise: anywhere, early ones included
        t = {$urandom, $urandom};
        send_req(swrm_pkg::op_t'($urandom_range(0, 1)), t[swrm_pkg::T_W-1:0]);
      end else if (r >= 94 && start != 0) begin
        t = 64'($urandom_range(0, 999)) % 64'(start);
        send_req(swrm_pkg::op_t'($urandom_range(0, 1)), start - 1 - t[swrm_pkg::T_W-1:0]);
      end else begin
        send_req(($urandom_range(0, 99) < 35) ? swrm_pkg::OP_QUERY : swrm_pkg::OP_HIT,
                 now_ns);
      end
    end
  endtask

  initial begin
    logic [swrm_pkg::T_W-1:0] rand_start;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset settings first
    random_phase(swrm_pkg::SPAN_RESET, '0, 100);

    // directed: early items, single bucket, full ring, large jump, edges
    set_meter(40'd10, 63'd1000);
    send_req(swrm_pkg::OP_QUERY, '0);
    send_req(swrm_pkg::OP_HIT, 63'd999);
    send_req(swrm_pkg::OP_HIT, 63'd1000);
    send_req(swrm_pkg::OP_HIT, 63'd1005);
    send_req(swrm_pkg::OP_QUERY, 63'd1009);
    send_req(swrm_pkg::OP_HIT, 63'd1010);
    send_req(swrm_pkg::OP_HIT, 63'd1025);
    send_req(swrm_pkg::OP_HIT, 63'd1025);
    send_req(swrm_pkg::OP_HIT, 63'd1155);
    send_req(swrm_pkg::OP_QUERY, 63'd1159);
    send_req(swrm_pkg::OP_HIT, 63'd1170);
    send_req(swrm_pkg::OP_QUERY, 63'd1175);
    send_req(swrm_pkg::OP_HIT, 63'd5000);
    send_req(swrm_pkg::OP_QUERY, 63'd5001);
    send_req(swrm_pkg::OP_HIT, T_MAX);
    send_req(swrm_pkg::OP_QUERY, T_MAX);
    send_req(swrm_pkg::OP_HIT, '0);
    send_req(swrm_pkg::OP_QUERY, 63'd1000);

    // zero span acts as one, widest span, high start, random settings
    set_meter(40'd0, 63'd5);
    random_phase(40'd0, 63'd5, 200);
    calm = 1'b1;
    set_meter(40'd1, '0);
    random_phase(40'd1, '0, 200);
    calm = 1'b0;
    rand_start = swrm_pkg::T_W'({$urandom, $urandom} >> 2);
    set_meter(swrm_pkg::STAT_MAX, rand_start);
    random_phase(swrm_pkg::STAT_MAX, rand_start, 200);
    set_meter(40'd7, T_MAX - 63'd2000);
    random_phase(40'd7, T_MAX - 63'd2000, 150);
    for (int p = 0; p < 4; p++) begin
      logic [swrm_pkg::SPAN_W-1:0] sp;
      sp = swrm_pkg::SPAN_W'($urandom_range(1, 500));
      rand_start = swrm_pkg::T_W'({$urandom, $urandom});
      calm = (p == 2);
      set_meter(sp, rand_start);
      random_phase(sp, rand_start, 200);
    end
    calm = 1'b0;

    drain();
    if (errors == 0) $display("sliding_window_rate_meter_unit test passed");
    else $display("sliding_window_rate_meter_unit test failed");
    $finish;
  end

endmodule
